FILE: src/sct_pkg.sv
// sct_pkg: shared types and codes for the settable countdown timer
// no dependencies; imported by sct_step and settable_countdown_timer
`default_nettype none

package sct_pkg;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_LEAVE  = 2'd2;

  localparam logic [2:0] KEY_SET   = 3'd1;
  localparam logic [2:0] KEY_SHIFT = 3'd2;
  localparam logic [2:0] KEY_ADD   = 3'd3;
  localparam logic [2:0] KEY_SUB   = 3'd4;

  localparam logic [1:0] MODE_RUNNING = 2'd0;
  localparam logic [1:0] MODE_EDIT    = 2'd1;
  localparam logic [1:0] MODE_STOPPED = 2'd2;
  localparam logic [1:0] MODE_DONE    = 2'd3;

  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  localparam logic [6:0] HOUR_MAX   = 7'd99;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [3:0] TENTH_MAX  = 4'd9;

  localparam logic [7:0] BLINK_RESET = 8'd150;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] tenths;
    logic [1:0] mode;
    logic [1:0] field;
    logic [8:0] blink_timer;
    logic       hidden;
  } state_t;

endpackage

`default_nettype wire

FILE: src/sct_step.sv
// sct_step: next-state logic of the countdown timer for one word
// depends on sct_pkg
`default_nettype none

module sct_step
  import sct_pkg::*;
(
  input  var state_t     cur,
  input  wire [1:0]      action,
  input  wire [2:0]      key,
  input  wire [7:0]      elapsed_ms,
  input  wire            view_active,
  input  wire [7:0]      half_period,
  output var state_t     nxt,
  output logic           ring
);

  function automatic logic [6:0] step_field(input logic [6:0] v, input logic [6:0] top,
                                            input logic up);
    logic [6:0] r;
    if (up) begin
      r = (v >= top) ? 7'd0 : v + 7'd1;
    end else begin
      r = (v == 7'd0 || v > top) ? top : v - 7'd1;
    end
    return r;
  endfunction

  logic       hms_zero;
  logic       all_zero;
  state_t     dec;
  logic [8:0] blink_sum;
  logic       up;

  assign hms_zero = (cur.hours == 7'd0) && (cur.minutes == 6'd0) && (cur.seconds == 6'd0);
  assign all_zero = hms_zero && (cur.tenths == 4'd0);
  assign blink_sum = cur.blink_timer + {1'b0, elapsed_ms};
  assign up = (key == KEY_ADD);

  // one tenth down with borrow; mode done when the result reaches zero
  always_comb begin
    dec = cur;
    if (cur.tenths != 4'd0) begin
      dec.tenths = cur.tenths - 4'd1;
    end else begin
      dec.tenths = TENTH_MAX;
      if (cur.seconds != 6'd0) begin
        dec.seconds = cur.seconds - 6'd1;
      end else begin
        dec.seconds = MINSEC_MAX;
        if (cur.minutes != 6'd0) begin
          dec.minutes = cur.minutes - 6'd1;
        end else begin
          dec.minutes = MINSEC_MAX;
          dec.hours = cur.hours - 7'd1;
        end
      end
    end
    if (dec.hours == 7'd0 && dec.minutes == 6'd0 && dec.seconds == 6'd0 &&
        dec.tenths == 4'd0) begin
      dec.mode = MODE_DONE;
    end
  end

  always_comb begin
    nxt = cur;
    ring = 1'b0;
    unique case (action)
      ACT_TICK: begin
        if (cur.mode == MODE_RUNNING) begin
          if (all_zero) begin
            nxt.mode = MODE_DONE;
          end else begin
            nxt = dec;
          end
        end
      end
      ACT_UPDATE: begin
        if (cur.mode == MODE_DONE) begin
          nxt.mode = MODE_STOPPED;
          ring = 1'b1;
        end
        if (nxt.mode == MODE_RUNNING || nxt.mode == MODE_STOPPED) begin
          if (view_active) begin
            if (key == KEY_SET) begin
              nxt.mode = MODE_EDIT;
            end else if (key == KEY_SHIFT) begin
              if (hms_zero || nxt.mode == MODE_RUNNING) begin
                nxt.mode = MODE_STOPPED;
              end else begin
                nxt.mode = MODE_RUNNING;
              end
            end
          end
        end else if (view_active) begin
          nxt.blink_timer = blink_sum;
          if (blink_sum >= {1'b0, half_period}) begin
            nxt.hidden = ~cur.hidden;
            nxt.blink_timer = 9'd0;
          end
          if (key == KEY_SET) begin
            nxt.mode = MODE_STOPPED;
            nxt.field = FIELD_HOURS;
            nxt.blink_timer = 9'd0;
            nxt.hidden = 1'b0;
            nxt.tenths = TENTH_MAX;
          end else if (key == KEY_SHIFT) begin
            nxt.field = (cur.field >= FIELD_SECONDS) ? FIELD_HOURS : cur.field + 2'd1;
          end else if (key == KEY_ADD || key == KEY_SUB) begin
            if (cur.field == FIELD_HOURS) begin
              nxt.hours = step_field(cur.hours, HOUR_MAX, up);
            end else if (cur.field == FIELD_MINUTES) begin
              nxt.minutes = 6'(step_field({1'b0, cur.minutes}, {1'b0, MINSEC_MAX}, up));
            end else begin
              nxt.seconds = 6'(step_field({1'b0, cur.seconds}, {1'b0, MINSEC_MAX}, up));
            end
            nxt.hidden = 1'b0;
            nxt.blink_timer = 9'd0;
          end
        end
      end
      ACT_LEAVE: begin
        nxt.field = FIELD_HOURS;
        nxt.blink_timer = 9'd0;
        nxt.hidden = 1'b0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/settable_countdown_timer.sv
// settable_countdown_timer: hh:mm:ss.t countdown with setting mode and blink
// depends on sct_pkg and sct_step
//
// input channel s_*: one word per event; s_tuser selects tick, key update or
//   leave, s_tdata carries key, elapsed milliseconds and foreground flag
// output channel m_*: one word per input word with the time, mode, selected
//   field, blank flag and ring pulse after that event
// config: cfg_we writes cfg_wdata into the blink half period (ms)
// path: an accepted input word goes into the input register, then the state
//   update writes the result word into the output register
// throughput: one word per cycle while the output is not stalled; the state
//   update is combinational, so consecutive words apply back to back
// stall: while m_tready is low the output word holds, one more word waits
//   in the input register, and s_tready then drops
// reset: rst clears the time to zero, mode counting, selection hours,
//   blink timer and blank flag cleared, half period 150 ms
`default_nettype none

module settable_countdown_timer
  import sct_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [7:0]            cfg_wdata,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [IN_DATA_W-1:0]  s_tdata,   // key[2:0], elapsed_ms[10:3], foreground[11]
  input  wire [IN_USER_W-1:0]  s_tuser,   // action[1:0]
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // hours[6:0], minutes[12:7], seconds[18:13],
                                          // tenths[22:19], mode[24:23],
                                          // selected_field[26:25], field_hidden[27],
                                          // ring[28]
);

  logic       in_valid;
  logic [1:0] in_action;
  logic [2:0] in_key;
  logic [7:0] in_elapsed;
  logic       in_fg;
  logic [7:0] half_period;
  state_t     st;
  state_t     st_next;
  logic       ring;
  logic       adv;
  logic       fire;
  logic       hidden_out;

  assign adv = !m_tvalid || m_tready;
  assign fire = in_valid && adv;
  assign s_tready = !in_valid || adv;
  assign hidden_out = (st_next.mode == MODE_EDIT) ? st_next.hidden : 1'b0;

  sct_step u_step (
    .cur           (st),
    .action        (in_action),
    .key           (in_key),
    .elapsed_ms    (in_elapsed),
    .view_active   (in_fg),
    .half_period   (half_period),
    .nxt           (st_next),
    .ring          (ring)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      half_period <= BLINK_RESET;
      st <= '{hours: 7'd0, minutes: 6'd0, seconds: 6'd0, tenths: 4'd0,
              mode: MODE_RUNNING, field: FIELD_HOURS, blink_timer: 9'd0,
              hidden: 1'b0};
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid <= in_valid;
      end
      if (fire) begin
        st <= st_next;
      end
      if (cfg_we) begin
        half_period <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_key <= s_tdata[2:0];
      in_elapsed <= s_tdata[10:3];
      in_fg <= s_tdata[11];
    end
    if (fire) begin
      m_tdata <= {3'b000, ring, hidden_out, st_next.field, st_next.mode, st_next.tenths,
                  st_next.seconds, st_next.minutes, st_next.hours};
    end
  end

`ifndef NO_ASSERTIONS
  a_ring_stops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |->
      m_tdata[24:23] != MODE_RUNNING && m_tdata[24:23] != MODE_DONE)
    else $error("ring outside stopped or setting mode");

  a_hidden_setting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[24:23] == MODE_EDIT)
    else $error("field blanked outside setting mode");

  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    st.tenths <= TENTH_MAX && st.minutes <= MINSEC_MAX && st.seconds <= MINSEC_MAX)
    else $error("time digit out of range");

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    st.hours <= HOUR_MAX && st.field <= FIELD_SECONDS)
    else $error("hours or selected field out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(fire) && !$past(rst) |-> $stable(st))
    else $error("state changed without a word");
`endif

endmodule

`default_nettype wire
